// ----- rtl/core/ema_pkg.sv -----
package ema_pkg;

  localparam int FIELD_W  = 32;
  localparam int ALIGN_W  = 31;
  localparam int STATUS_W = 2;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NOFIT = 2'd1;
  localparam logic [STATUS_W-1:0] ST_DROP  = 2'd2;

  localparam logic CMD_FREE  = 1'b0;
  localparam logic CMD_ALLOC = 1'b1;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_FR_INIT,
    OP_RD_IDX,
    OP_SCAN_STEP,
    OP_MERGE_PREV,
    OP_MERGE_NEXT,
    OP_SHU_GROW,
    OP_DROP_NEW,
    OP_RD_LAST,
    OP_CAP_DROP,
    OP_SHU_RD,
    OP_SHU_WR,
    OP_PUT,
    OP_SHD_INIT,
    OP_SHD_RD,
    OP_SHD_WR,
    OP_DEC,
    OP_AL_CAP,
    OP_EVAL,
    OP_ALIGN,
    OP_TAKE,
    OP_IDX_INC,
    OP_FIN
  } dp_op_t;

  typedef struct packed {
    logic cnt_zero;
    logic n_zero;
    logic scan_le;
    logic idx_more;
    logic merge_prev;
    logic merge_next;
    logic full;
    logic at_end;
    logic shu_more;
    logic shd_more;
    logic pend;
    logic brk_base;
    logic skip_off;
    logic brk_len;
    logic align_on;
    logic div_done;
    logic r_lt_m;
    logic no_fit;
    logic take_empty;
    logic frag;
  } dp_sts_t;

endpackage

// ----- rtl/core/ema_ram.sv -----
module ema_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/core/ema_div.sv -----
module ema_div #(
  parameter int NUM_W = 32,
  parameter int DEN_W = 31
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [DEN_W-1:0] rem
);

  localparam int SW = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] num_r, num_nxt;
  logic [DEN_W-1:0] den_r, den_nxt;
  logic [DEN_W-1:0] rem_r, rem_nxt;
  logic [SW-1:0]    step_r, step_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;
  logic             ge;

  assign trial = {rem_r, num_r[NUM_W-1]};
  assign diff  = trial - {1'b0, den_r};
  assign ge    = trial >= {1'b0, den_r};

  always_comb begin
    num_nxt  = num_r;
    den_nxt  = den_r;
    rem_nxt  = rem_r;
    step_nxt = step_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      num_nxt  = num;
      den_nxt  = den;
      rem_nxt  = '0;
      step_nxt = SW'(NUM_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt  = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      num_nxt  = {num_r[NUM_W-2:0], 1'b0};
      step_nxt = step_r - SW'(1);
      if (step_r == SW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    num_r  <= num_nxt;
    den_r  <= den_nxt;
    rem_r  <= rem_nxt;
    step_r <= step_nxt;
  end

  assign done = done_r;
  assign rem  = rem_r;

endmodule

// ----- rtl/core/ema_datapath.sv -----
module ema_datapath #(
  parameter int MAP_SLOTS = 64,
  parameter int ADDR_BITS = 32
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  ema_pkg::dp_op_t                 op,
  input  logic [ema_pkg::FIELD_W-1:0]     in_req_address,
  input  logic [ema_pkg::FIELD_W-1:0]     in_req_length,
  input  logic [ema_pkg::ALIGN_W-1:0]     in_alignment,
  input  logic                            in_command,
  output ema_pkg::dp_sts_t                sts,
  output logic [ema_pkg::FIELD_W-1:0]     out_granted_address,
  output logic [ema_pkg::STATUS_W-1:0]    out_status,
  output logic [ema_pkg::FIELD_W-1:0]     out_dropped_base,
  output logic [ema_pkg::FIELD_W-1:0]     out_dropped_length
);

  localparam int AB = ADDR_BITS;
  localparam int IW = $clog2(MAP_SLOTS);
  localparam int CW = $clog2(MAP_SLOTS + 1);
  localparam int XW = ((ADDR_BITS > ema_pkg::ALIGN_W) ? ADDR_BITS : ema_pkg::ALIGN_W) + 1;
  localparam int EW = 2 * ADDR_BITS;

  logic [CW-1:0] cnt_r, cnt_nxt, idx_r, idx_nxt, k_r, k_nxt;
  logic [AB-1:0] a_r, a_nxt, n_r, n_nxt, addr_r, addr_nxt, len_r, len_nxt;
  logic [ema_pkg::ALIGN_W-1:0] al_r, al_nxt;
  logic [AB-1:0] prev_s_r, prev_s_nxt, prev_z_r, prev_z_nxt;
  logic [AB-1:0] next_s_r, next_s_nxt, next_z_r, next_z_nxt;
  logic [AB-1:0] base_r, base_nxt, sz_r, sz_nxt, m_r, m_nxt, t_r, t_nxt;
  logic [AB-1:0] granted_r, granted_nxt, db_r, db_nxt, dl_r, dl_nxt;
  logic [ema_pkg::STATUS_W-1:0] status_r, status_nxt;
  logic          pend_r, pend_nxt, grow_r, grow_nxt;
  logic [ema_pkg::FIELD_W-1:0]  og_r, og_nxt, odb_r, odb_nxt, odl_r, odl_nxt;
  logic [ema_pkg::STATUS_W-1:0] ost_r, ost_nxt;

  logic          we, re;
  logic [CW-1:0] waddr_c, raddr_c;
  logic [EW-1:0] wdata, rdata;
  logic [AB-1:0] rd_start, rd_size;

  logic          fixed;
  logic [AB-1:0] off1, off2, rest, m0, r_al;
  logic [XW-1:0] t_x;
  logic [ema_pkg::ALIGN_W-1:0] div_rem;
  logic          div_done, div_start;

  assign rd_start = rdata[EW-1:AB];
  assign rd_size  = rdata[AB-1:0];

  assign fixed = addr_r != '0;
  assign off1  = addr_r - base_r;
  assign m0    = fixed ? addr_r : base_r;
  assign t_x   = XW'(m0) + XW'(al_r) - XW'(1);
  assign r_al  = AB'(XW'(t_r) - XW'(div_rem));
  assign off2  = m_r - base_r;
  assign rest  = sz_r - off2 - len_r;
  assign div_start = (op == ema_pkg::OP_EVAL) && (al_r != '0);

  always_comb begin
    sts.cnt_zero   = cnt_r == '0;
    sts.n_zero     = n_r == '0;
    sts.scan_le    = rd_start <= a_r;
    sts.idx_more   = (idx_r + CW'(1)) < cnt_r;
    sts.merge_prev = (idx_r != '0) && ((prev_s_r + prev_z_r) == a_r);
    sts.merge_next = (idx_r < cnt_r) && ((a_r + n_r) == next_s_r);
    sts.full       = cnt_r == CW'(MAP_SLOTS);
    sts.at_end     = idx_r >= cnt_r;
    sts.shu_more   = k_r > idx_r;
    sts.shd_more   = (k_r + CW'(1)) < cnt_r;
    sts.pend       = pend_r;
    sts.brk_base   = fixed && (base_r > addr_r);
    sts.skip_off   = fixed && (off1 > sz_r);
    sts.brk_len    = fixed && (len_r > (sz_r - off1));
    sts.align_on   = al_r != '0;
    sts.div_done   = div_done;
    sts.r_lt_m     = r_al < m_r;
    sts.no_fit     = (off2 > sz_r) || ((sz_r - off2) < len_r);
    sts.take_empty = rest == '0;
    sts.frag       = off2 != '0;
  end

  always_comb begin
    cnt_nxt = cnt_r;  idx_nxt = idx_r;  k_nxt = k_r;
    a_nxt = a_r;  n_nxt = n_r;  addr_nxt = addr_r;  len_nxt = len_r;  al_nxt = al_r;
    prev_s_nxt = prev_s_r;  prev_z_nxt = prev_z_r;
    next_s_nxt = next_s_r;  next_z_nxt = next_z_r;
    base_nxt = base_r;  sz_nxt = sz_r;  m_nxt = m_r;  t_nxt = t_r;
    granted_nxt = granted_r;  db_nxt = db_r;  dl_nxt = dl_r;  status_nxt = status_r;
    pend_nxt = pend_r;  grow_nxt = grow_r;
    og_nxt = og_r;  odb_nxt = odb_r;  odl_nxt = odl_r;  ost_nxt = ost_r;
    we = 1'b0;  re = 1'b0;  waddr_c = '0;  raddr_c = '0;  wdata = '0;
    unique case (op)
      ema_pkg::OP_NONE: begin
      end
      ema_pkg::OP_LOAD: begin
        a_nxt       = AB'(in_req_address);
        n_nxt       = AB'(in_req_length);
        addr_nxt    = AB'(in_req_address);
        len_nxt     = AB'(in_req_length);
        al_nxt      = in_alignment;
        idx_nxt     = '0;
        status_nxt  = (in_command == ema_pkg::CMD_ALLOC) ? ema_pkg::ST_NOFIT : ema_pkg::ST_OK;
        granted_nxt = '0;
        db_nxt      = '0;
        dl_nxt      = '0;
        pend_nxt    = 1'b0;
      end
      ema_pkg::OP_FR_INIT: begin
        idx_nxt  = '0;
        pend_nxt = 1'b0;
        re       = 1'b1;
        raddr_c  = '0;
      end
      ema_pkg::OP_RD_IDX: begin
        re      = 1'b1;
        raddr_c = idx_r;
      end
      ema_pkg::OP_SCAN_STEP: begin
        if (rd_start <= a_r) begin
          prev_s_nxt = rd_start;
          prev_z_nxt = rd_size;
          idx_nxt    = idx_r + CW'(1);
        end else begin
          next_s_nxt = rd_start;
          next_z_nxt = rd_size;
        end
      end
      ema_pkg::OP_MERGE_PREV: begin
        we      = 1'b1;
        waddr_c = idx_r - CW'(1);
        wdata   = {prev_s_r, prev_z_r + n_r + (sts.merge_next ? next_z_r : '0)};
      end
      ema_pkg::OP_MERGE_NEXT: begin
        we      = 1'b1;
        waddr_c = idx_r;
        wdata   = {next_s_r - n_r, next_z_r + n_r};
      end
      ema_pkg::OP_SHU_GROW: begin
        k_nxt    = cnt_r;
        grow_nxt = 1'b1;
      end
      ema_pkg::OP_DROP_NEW: begin
        db_nxt     = a_r;
        dl_nxt     = n_r;
        status_nxt = ema_pkg::ST_DROP;
      end
      ema_pkg::OP_RD_LAST: begin
        re      = 1'b1;
        raddr_c = cnt_r - CW'(1);
      end
      ema_pkg::OP_CAP_DROP: begin
        db_nxt     = rd_start;
        dl_nxt     = rd_size;
        status_nxt = ema_pkg::ST_DROP;
        k_nxt      = cnt_r - CW'(1);
        grow_nxt   = 1'b0;
      end
      ema_pkg::OP_SHU_RD: begin
        re      = 1'b1;
        raddr_c = k_r - CW'(1);
      end
      ema_pkg::OP_SHU_WR: begin
        we      = 1'b1;
        waddr_c = k_r;
        wdata   = rdata;
        k_nxt   = k_r - CW'(1);
      end
      ema_pkg::OP_PUT: begin
        we      = 1'b1;
        waddr_c = idx_r;
        wdata   = {a_r, n_r};
        if (grow_r) begin
          cnt_nxt = cnt_r + CW'(1);
        end
      end
      ema_pkg::OP_SHD_INIT: begin
        k_nxt = idx_r;
      end
      ema_pkg::OP_SHD_RD: begin
        re      = 1'b1;
        raddr_c = k_r + CW'(1);
      end
      ema_pkg::OP_SHD_WR: begin
        we      = 1'b1;
        waddr_c = k_r;
        wdata   = rdata;
        k_nxt   = k_r + CW'(1);
      end
      ema_pkg::OP_DEC: begin
        cnt_nxt = cnt_r - CW'(1);
      end
      ema_pkg::OP_AL_CAP: begin
        base_nxt = rd_start;
        sz_nxt   = rd_size;
      end
      ema_pkg::OP_EVAL: begin
        m_nxt = m0;
        t_nxt = t_x[AB-1:0];
      end
      ema_pkg::OP_ALIGN: begin
        m_nxt = r_al;
      end
      ema_pkg::OP_TAKE: begin
        we          = rest != '0;
        waddr_c     = idx_r;
        wdata       = {m_r + len_r, rest};
        granted_nxt = m_r;
        status_nxt  = ema_pkg::ST_OK;
        a_nxt       = base_r;
        n_nxt       = off2;
        pend_nxt    = off2 != '0;
      end
      ema_pkg::OP_IDX_INC: begin
        idx_nxt = idx_r + CW'(1);
      end
      ema_pkg::OP_FIN: begin
        og_nxt  = ema_pkg::FIELD_W'(granted_r);
        odb_nxt = ema_pkg::FIELD_W'(db_r);
        odl_nxt = ema_pkg::FIELD_W'(dl_r);
        ost_nxt = status_r;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;  k_r <= k_nxt;
    a_r <= a_nxt;  n_r <= n_nxt;  addr_r <= addr_nxt;  len_r <= len_nxt;  al_r <= al_nxt;
    prev_s_r <= prev_s_nxt;  prev_z_r <= prev_z_nxt;
    next_s_r <= next_s_nxt;  next_z_r <= next_z_nxt;
    base_r <= base_nxt;  sz_r <= sz_nxt;  m_r <= m_nxt;  t_r <= t_nxt;
    granted_r <= granted_nxt;  db_r <= db_nxt;  dl_r <= dl_nxt;  status_r <= status_nxt;
    pend_r <= pend_nxt;  grow_r <= grow_nxt;
    og_r <= og_nxt;  odb_r <= odb_nxt;  odl_r <= odl_nxt;  ost_r <= ost_nxt;
  end

  ema_ram #(
    .WIDTH(EW),
    .DEPTH(MAP_SLOTS)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr_c[IW-1:0]),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr_c[IW-1:0]),
    .rdata (rdata)
  );

  ema_div #(
    .NUM_W(AB),
    .DEN_W(ema_pkg::ALIGN_W)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (t_x[AB-1:0]),
    .den   (al_r),
    .done  (div_done),
    .rem   (div_rem)
  );

  assign out_granted_address = og_r;
  assign out_status          = ost_r;
  assign out_dropped_base    = odb_r;
  assign out_dropped_length  = odl_r;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(MAP_SLOTS))
    else $error("extent count past table size");

  a_dec_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (op == ema_pkg::OP_DEC) |-> (cnt_r != '0))
    else $error("remove from empty table");

  a_grow_room: assert property (@(posedge clk) disable iff (!rst_n)
    (op == ema_pkg::OP_PUT && grow_r) |-> (cnt_r < CW'(MAP_SLOTS)))
    else $error("insert grows a full table");

endmodule

// ----- rtl/core/ema_ctrl.sv -----
module ema_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic             in_command,
  output logic             in_stall,
  output logic             out_valid,
  input  logic             out_stall,
  input  ema_pkg::dp_sts_t sts,
  output ema_pkg::dp_op_t  op
);

  typedef enum logic [16:0] {
    S_IDLE      = 17'h00001,
    S_FR_START  = 17'h00002,
    S_SC_RD     = 17'h00004,
    S_SC_CHK    = 17'h00008,
    S_FR_DECIDE = 17'h00010,
    S_DROP_CAP  = 17'h00020,
    S_SHU_RD    = 17'h00040,
    S_SHU_WR    = 17'h00080,
    S_SHD_INIT  = 17'h00100,
    S_SHD_RD    = 17'h00200,
    S_SHD_WR    = 17'h00400,
    S_AL_RD     = 17'h00800,
    S_AL_CHK    = 17'h01000,
    S_AL_EVAL   = 17'h02000,
    S_AL_DIV    = 17'h04000,
    S_AL_FIT    = 17'h08000,
    S_FIN       = 17'h10000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    op            = ema_pkg::OP_NONE;
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && out_stall;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op = ema_pkg::OP_LOAD;
          if (in_command == ema_pkg::CMD_ALLOC) begin
            state_nxt = sts.cnt_zero ? S_FIN : S_AL_RD;
          end else begin
            state_nxt = S_FR_START;
          end
        end
      end
      S_FR_START: begin
        op = ema_pkg::OP_FR_INIT;
        priority if (sts.n_zero) state_nxt = S_FIN;
        else if (sts.cnt_zero)   state_nxt = S_FR_DECIDE;
        else                     state_nxt = S_SC_CHK;
      end
      S_SC_RD: begin
        op        = ema_pkg::OP_RD_IDX;
        state_nxt = S_SC_CHK;
      end
      S_SC_CHK: begin
        op        = ema_pkg::OP_SCAN_STEP;
        state_nxt = (sts.scan_le && sts.idx_more) ? S_SC_RD : S_FR_DECIDE;
      end
      S_FR_DECIDE: begin
        priority if (sts.merge_prev) begin
          op        = ema_pkg::OP_MERGE_PREV;
          state_nxt = sts.merge_next ? S_SHD_INIT : S_FIN;
        end else if (sts.merge_next) begin
          op        = ema_pkg::OP_MERGE_NEXT;
          state_nxt = S_FIN;
        end else if (!sts.full) begin
          op        = ema_pkg::OP_SHU_GROW;
          state_nxt = S_SHU_RD;
        end else if (sts.at_end) begin
          op        = ema_pkg::OP_DROP_NEW;
          state_nxt = S_FIN;
        end else begin
          op        = ema_pkg::OP_RD_LAST;
          state_nxt = S_DROP_CAP;
        end
      end
      S_DROP_CAP: begin
        op        = ema_pkg::OP_CAP_DROP;
        state_nxt = S_SHU_RD;
      end
      S_SHU_RD: begin
        if (sts.shu_more) begin
          op        = ema_pkg::OP_SHU_RD;
          state_nxt = S_SHU_WR;
        end else begin
          op        = ema_pkg::OP_PUT;
          state_nxt = S_FIN;
        end
      end
      S_SHU_WR: begin
        op        = ema_pkg::OP_SHU_WR;
        state_nxt = S_SHU_RD;
      end
      S_SHD_INIT: begin
        op        = ema_pkg::OP_SHD_INIT;
        state_nxt = S_SHD_RD;
      end
      S_SHD_RD: begin
        if (sts.shd_more) begin
          op        = ema_pkg::OP_SHD_RD;
          state_nxt = S_SHD_WR;
        end else begin
          op        = ema_pkg::OP_DEC;
          state_nxt = sts.pend ? S_FR_START : S_FIN;
        end
      end
      S_SHD_WR: begin
        op        = ema_pkg::OP_SHD_WR;
        state_nxt = S_SHD_RD;
      end
      S_AL_RD: begin
        op        = ema_pkg::OP_RD_IDX;
        state_nxt = S_AL_CHK;
      end
      S_AL_CHK: begin
        op        = ema_pkg::OP_AL_CAP;
        state_nxt = S_AL_EVAL;
      end
      S_AL_EVAL: begin
        priority if (sts.brk_base) begin
          state_nxt = S_FIN;
        end else if (sts.skip_off) begin
          op        = ema_pkg::OP_IDX_INC;
          state_nxt = sts.idx_more ? S_AL_RD : S_FIN;
        end else if (sts.brk_len) begin
          state_nxt = S_FIN;
        end else begin
          op        = ema_pkg::OP_EVAL;
          state_nxt = sts.align_on ? S_AL_DIV : S_AL_FIT;
        end
      end
      S_AL_DIV: begin
        if (sts.div_done) begin
          if (sts.r_lt_m) begin
            op        = ema_pkg::OP_IDX_INC;
            state_nxt = sts.idx_more ? S_AL_RD : S_FIN;
          end else begin
            op        = ema_pkg::OP_ALIGN;
            state_nxt = S_AL_FIT;
          end
        end
      end
      S_AL_FIT: begin
        if (sts.no_fit) begin
          op        = ema_pkg::OP_IDX_INC;
          state_nxt = sts.idx_more ? S_AL_RD : S_FIN;
        end else begin
          op = ema_pkg::OP_TAKE;
          priority if (sts.take_empty) state_nxt = S_SHD_INIT;
          else if (sts.frag)           state_nxt = S_FR_START;
          else                         state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (!out_valid_r || !out_stall) begin
          op            = ema_pkg::OP_FIN;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = state_r != S_IDLE;
  assign out_valid = out_valid_r;

  a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE && in_valid) |=> (state_r != S_IDLE))
    else $error("request taken but controller stayed idle");

  a_hold_pending: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIN && out_valid_r && out_stall) |=> (state_r == S_FIN))
    else $error("result overwritten while pending");

  a_valid_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == S_FIN))
    else $error("result valid without finishing a request");

endmodule

// ----- rtl/core/extent_map_allocator_unit.sv -----
// Free-extent table with first-fit allocation and coalescing free.
// Input channel (in_valid/in_stall): one request per handshake. Command
// free inserts [req_address, +req_length) and merges with its neighbors;
// command allocate searches first-fit, optionally from a fixed start and
// rounded up to alignment. Output channel (out_valid/out_stall): exactly
// one result per request, held in an output register until taken.
// Operation: a request is worked on alone, at most one table access per cycle.
// Free scans the extents in order and then shifts extents to make or close
// a slot. Allocate walks the extents; when alignment is nonzero, each
// candidate extent also waits on a bit-serial remainder unit, and any
// leading fragment is then freed as above. The table RAM, with at most one
// access per cycle, paces both commands.
// in_stall is high from acceptance until the result is loaded into the
// output register; a new request is taken while that result waits. If the
// receiver stalls, the next result waits in the controller until the
// output register is free.
// Reset empties the table at once (count to zero); no clearing pass.
module extent_map_allocator_unit #(
  parameter int MAP_SLOTS = 64,
  parameter int ADDR_BITS = 32
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         in_command,
  input  logic [ema_pkg::FIELD_W-1:0]  in_req_address,
  input  logic [ema_pkg::FIELD_W-1:0]  in_req_length,
  input  logic [ema_pkg::ALIGN_W-1:0]  in_alignment,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [ema_pkg::FIELD_W-1:0]  out_granted_address,
  output logic [ema_pkg::STATUS_W-1:0] out_status,
  output logic [ema_pkg::FIELD_W-1:0]  out_dropped_base,
  output logic [ema_pkg::FIELD_W-1:0]  out_dropped_length
);

  ema_pkg::dp_op_t  op;
  ema_pkg::dp_sts_t sts;

  ema_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_command (in_command),
    .in_stall   (in_stall),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .sts        (sts),
    .op         (op)
  );

  ema_datapath #(
    .MAP_SLOTS(MAP_SLOTS),
    .ADDR_BITS(ADDR_BITS)
  ) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .op                  (op),
    .in_req_address      (in_req_address),
    .in_req_length       (in_req_length),
    .in_alignment        (in_alignment),
    .in_command          (in_command),
    .sts                 (sts),
    .out_granted_address (out_granted_address),
    .out_status          (out_status),
    .out_dropped_base    (out_dropped_base),
    .out_dropped_length  (out_dropped_length)
  );

endmodule

// ----- verif/extent_map_checker.sv -----
module extent_map_checker (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  input  logic                         in_stall,
  input  logic                         in_command,
  input  logic [ema_pkg::FIELD_W-1:0]  in_req_address,
  input  logic [ema_pkg::FIELD_W-1:0]  in_req_length,
  input  logic [ema_pkg::ALIGN_W-1:0]  in_alignment,
  input  logic                         out_valid,
  input  logic                         out_stall,
  input  logic [ema_pkg::FIELD_W-1:0]  out_granted_address,
  input  logic [ema_pkg::STATUS_W-1:0] out_status,
  input  logic [ema_pkg::FIELD_W-1:0]  out_dropped_base,
  input  logic [ema_pkg::FIELD_W-1:0]  out_dropped_length,
  output int                           fail_count,
  output int                           pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import ema_pkg::*;

  localparam int SLOTS = 64;

  typedef struct {
    logic [FIELD_W-1:0]  grant;
    logic [STATUS_W-1:0] status;
    logic [FIELD_W-1:0]  drop_base;
    logic [FIELD_W-1:0]  drop_len;
  } grant_t;

  grant_t grant_queue[$];
  logic [FIELD_W-1:0] ext_base[SLOTS];
  logic [FIELD_W-1:0] ext_len[SLOTS];
  int ext_cnt;

  function automatic void drop_slot(int i);
    for (int k = i; k + 1 < ext_cnt; k++) begin
      ext_base[k] = ext_base[k+1];
      ext_len[k] = ext_len[k+1];
    end
    if (ext_cnt > 0) ext_cnt--;
  endfunction

  function automatic logic [STATUS_W-1:0] insert_range(
    input logic [FIELD_W-1:0] a, input logic [FIELD_W-1:0] n,
    inout logic [FIELD_W-1:0] db, inout logic [FIELD_W-1:0] dl);
    int i;
    logic [FIELD_W-1:0] stop;
    i = 0;
    if (n == 0) return ST_OK;
    while (i < ext_cnt && ext_base[i] <= a) i++;
    stop = a + n;
    if (i > 0 && ext_base[i-1] + ext_len[i-1] == a) begin
      ext_len[i-1] = ext_len[i-1] + n;
      if (i < ext_cnt && stop == ext_base[i]) begin
        ext_len[i-1] = ext_len[i-1] + ext_len[i];
        drop_slot(i);
      end
      return ST_OK;
    end
    if (i < ext_cnt && stop == ext_base[i]) begin
      ext_base[i] = ext_base[i] - n;
      ext_len[i] = ext_len[i] + n;
      return ST_OK;
    end
    if (ext_cnt < SLOTS) begin
      for (int k = ext_cnt; k > i; k--) begin
        ext_base[k] = ext_base[k-1];
        ext_len[k] = ext_len[k-1];
      end
      ext_base[i] = a;
      ext_len[i] = n;
      ext_cnt++;
      return ST_OK;
    end
    if (i >= ext_cnt) begin
      db = a;
      dl = n;
      return ST_DROP;
    end
    db = ext_base[ext_cnt-1];
    dl = ext_len[ext_cnt-1];
    for (int k = ext_cnt - 1; k > i; k--) begin
      ext_base[k] = ext_base[k-1];
      ext_len[k] = ext_len[k-1];
    end
    ext_base[i] = a;
    ext_len[i] = n;
    return ST_DROP;
  endfunction

  function automatic grant_t predict_grant(input logic cmd, input logic [FIELD_W-1:0] addr,
    input logic [FIELD_W-1:0] n, input logic [ALIGN_W-1:0] al);
    grant_t g;
    logic [FIELD_W-1:0] base, sz, m, off, r;
    longint unsigned t;
    g = '{grant: '0, status: ST_OK, drop_base: '0, drop_len: '0};
    if (cmd == CMD_FREE) begin
      g.status = insert_range(addr, n, g.drop_base, g.drop_len);
      return g;
    end
    g.status = ST_NOFIT;
    for (int i = 0; i < ext_cnt; i++) begin
      base = ext_base[i];
      sz = ext_len[i];
      m = base;
      if (addr != 0) begin
        if (base > addr) break;
        off = addr - base;
        if (off > sz) continue;
        if (n > sz - off) break;
        m = addr;
      end
      if (al != 0) begin
        t = (longint'(m) + longint'(al) - 1) & 64'hFFFF_FFFF;
        r = FIELD_W'(((t / al) * al) & 64'hFFFF_FFFF);
        if (r < m) continue;
        m = r;
      end
      off = m - base;
      if (off > sz || sz - off < n) continue;
      ext_base[i] = m + n;
      ext_len[i] = sz - off - n;
      if (ext_len[i] == 0) drop_slot(i);
      g.status = ST_OK;
      if (off != 0) g.status = insert_range(base, off, g.drop_base, g.drop_len);
      g.grant = m;
      break;
    end
    return g;
  endfunction

  initial begin
    fail_count = 0;
    pending = 0;
    ext_cnt = 0;
  end

  always @(posedge clk) begin
    grant_t exp_g;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (grant_queue.size() == 0) begin
          $error("result with no request outstanding");
          fail_count++;
        end else begin
          exp_g = grant_queue.pop_front();
          if (out_granted_address !== exp_g.grant) begin
            $error("granted_address exp %h got %h", exp_g.grant, out_granted_address);
            fail_count++;
          end
          if (out_status !== exp_g.status) begin
            $error("status exp %0d got %0d", exp_g.status, out_status);
            fail_count++;
          end
          if (out_dropped_base !== exp_g.drop_base) begin
            $error("dropped_base exp %h got %h", exp_g.drop_base, out_dropped_base);
            fail_count++;
          end
          if (out_dropped_length !== exp_g.drop_len) begin
            $error("dropped_length exp %h got %h", exp_g.drop_len, out_dropped_length);
            fail_count++;
          end
        end
      end
      if (in_valid && !in_stall)
        grant_queue.push_back(predict_grant(in_command, in_req_address, in_req_length,
                                            in_alignment));
      pending = grant_queue.size();
    end
  end
endmodule

// ----- verif/tb_top.sv -----
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import ema_pkg::*;

  localparam int WATCHDOG_LIMIT = 60000;
  localparam logic [31:0] REGION = 32'h1000_0000;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  logic                in_command;
  logic [FIELD_W-1:0]  in_req_address;
  logic [FIELD_W-1:0]  in_req_length;
  logic [ALIGN_W-1:0]  in_alignment;
  logic                out_valid;
  logic                out_stall;
  logic [FIELD_W-1:0]  out_granted_address;
  logic [STATUS_W-1:0] out_status;
  logic [FIELD_W-1:0]  out_dropped_base;
  logic [FIELD_W-1:0]  out_dropped_length;
  int fail_count;
  int pending;
  int idle_cycles;
  bit hold_out;

  extent_map_allocator_unit uut (.*);

  extent_map_checker chk (.*);

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  task automatic send(input logic cmd, input logic [31:0] a, input logic [31:0] n,
                      input logic [30:0] al);
    in_valid <= 1'b1;
    in_command <= cmd;
    in_req_address <= a;
    in_req_length <= n;
    in_alignment <= al;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic sender_gap();
    int n;
    n = 0;
    if ($urandom_range(0, 2) == 0) n = $urandom_range(1, 4);
    if ($urandom_range(0, 60) == 0) n = $urandom_range(50, 300);
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic send_random();
    int sel;
    logic [31:0] a, n;
    logic [30:0] al;
    sel = $urandom_range(0, 99);
    a = REGION + ($urandom_range(0, 255) << 6);
    n = $urandom_range(1, 16) << 4;
    case ($urandom_range(0, 5))
      0, 1, 2: al = '0;
      3: al = 31'(1) << $urandom_range(4, 10);
      4: al = 31'($urandom_range(1, 200));
      default: al = 31'($urandom_range(1, 31'h7FFF_FFFF));
    endcase
    if (sel < 6) begin
      send(1'($urandom_range(0, 1)), $urandom, $urandom, 31'($urandom));
    end else if (sel < 55) begin
      if ($urandom_range(0, 3) == 0) n = 16;
      send(CMD_FREE, a, n, 31'($urandom));
    end else if (sel < 80) begin
      send(CMD_ALLOC, 32'h0, $urandom_range(0, 8) << 4, al);
    end else begin
      send(CMD_ALLOC, a + ($urandom_range(0, 3) << 4), n, al);
    end
  endtask

  initial begin
    out_stall = 1'b0;
    @(posedge clk);
    forever begin
      if (hold_out) begin
        out_stall <= 1'b1;
        repeat (3000) @(posedge clk);
        hold_out = 1'b0;
        out_stall <= 1'b0;
        @(posedge clk);
      end else if ($urandom_range(0, 199) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(40, 200)) @(posedge clk);
      end else begin
        out_stall <= ($urandom_range(0, 3) == 0);
        @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_command = CMD_FREE;
    in_req_address = '0;
    in_req_length = '0;
    in_alignment = '0;
    idle_cycles = 0;
    hold_out = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed
    send(CMD_ALLOC, 32'h0, 32'h10, '0);
    send(CMD_FREE, 32'h100, 32'h0, '0);
    send(CMD_FREE, 32'h100, 32'h100, '0);
    send(CMD_FREE, 32'h300, 32'h100, '0);
    send(CMD_FREE, 32'h200, 32'h100, '0);
    send(CMD_FREE, 32'h80, 32'h80, '0);
    send(CMD_ALLOC, 32'h0, 32'h0, '0);
    send(CMD_ALLOC, 32'h150, 32'h20, 31'h40);
    send(CMD_ALLOC, 32'h50, 32'h10, '0);
    send(CMD_ALLOC, 32'h380, 32'h100, '0);
    send(CMD_FREE, 32'hFFFF_FFF0, 32'h20, '0);
    send(CMD_ALLOC, 32'h0, 32'h8, 31'h4000_0000);
    send(CMD_ALLOC, 32'h0, 32'h4, 31'h7FFF_FFFF);
    send(CMD_ALLOC, 32'h0, 32'hFFFF_FFFF, '0);
    send(CMD_ALLOC, 32'hFFFF_FFFF, 32'h1, '0);
    send(CMD_FREE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 31'h7FFF_FFFF);
    for (int k = 0; k < 68; k++) send(CMD_FREE, 32'h10_0000 + (k << 8), 32'h10, '0);
    send(CMD_FREE, 32'h8000_0000, 32'h10, '0);
    send(CMD_FREE, 32'h10_0080, 32'h10, '0);
    send(CMD_ALLOC, 32'h10_0200, 32'h20, '0);
    send(CMD_ALLOC, 32'h10_0304, 32'h4, '0);
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);

    for (int k = 0; k < 1700; k++) begin
      if (k == 500) hold_out = 1'b1;
      if (k == 1000 || k == 1400) begin
        in_valid <= 1'b0;
        while (pending != 0) @(posedge clk);
      end
      send_random();
      sender_gap();
    end
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (600) @(posedge clk);
    if (fail_count == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end
endmodule

// ----- sim.f -----
rtl/core/ema_pkg.sv
rtl/core/ema_ram.sv
rtl/core/ema_div.sv
rtl/core/ema_datapath.sv
rtl/core/ema_ctrl.sv
rtl/core/extent_map_allocator_unit.sv
verif/extent_map_checker.sv
verif/tb_top.sv
